/* hw/rtl/bulk_only_transport_host_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bulk-only transport host engine
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BULK_ONLY_TRANSPORT_HOST_ENGINE_TOP_DEFINES_SVH
`define BULK_ONLY_TRANSPORT_HOST_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define BOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bot assertion failed");

// Next-cycle implication, disabled during reset
`define BOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bot assertion failed");

`else

`define BOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/bot_pkg.sv */
// ----------------------------------------------------------------------------
// bot_pkg
// Types, codes and constants shared by the bulk-only transport host engine.
// ----------------------------------------------------------------------------
package bot_pkg;

    // Chunk size default; clamped to 1..255 inside the step logic
    localparam int MAX_CHUNK_DEFAULT = 128;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_READY      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_BLOCK = 1'd1;
    localparam logic [16:0]          BPB_RESET           = 17'd512;

    // Input transaction kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_XFAIL   = 2'd2;

    // Request operations
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Status wrapper
    localparam logic [31:0] CSW_SIG       = 32'h5342_5355;
    localparam logic [7:0]  CSW_PASSED    = 8'd0;
    localparam logic [7:0]  CSW_FAILED    = 8'd1;

    // SCSI opcodes and command lengths
    localparam logic [7:0] SCSI_READ10       = 8'h28;
    localparam logic [7:0] SCSI_WRITE10      = 8'h2A;
    localparam logic [7:0] SCSI_SYNC_CACHE10 = 8'h35;
    localparam logic [7:0] SCSI_REQ_SENSE    = 8'h03;
    localparam logic [3:0] CDB_LEN_10        = 4'd10;
    localparam logic [3:0] CDB_LEN_6         = 4'd6;
    localparam logic [4:0] SENSE_ALLOC_LEN   = 5'd18;

    // Result kinds
    localparam logic RES_COMMAND    = 1'b0;
    localparam logic RES_COMPLETION = 1'b1;

    typedef enum logic [2:0] {
        CC_OK         = 3'd0,
        CC_NOT_READY  = 3'd1,
        CC_TRANSPORT  = 3'd2,
        CC_BAD_CSW    = 3'd3,
        CC_FAILED     = 3'd4,
        CC_PHASE      = 3'd5,
        CC_BUSY       = 3'd6,
        CC_UNEXPECTED = 3'd7
    } t_ccode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CMD   = 2'd1,
        PH_SENSE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  request_op;
        logic [31:0] start_block;
        logic [31:0] block_total;
        logic [31:0] status_signature;
        logic [31:0] status_tag;
        logic [7:0]  status_code;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] wrapper_tag;
        logic [23:0] transfer_bytes;
        logic        direction_in;
        logic [3:0]  command_length;
        logic [7:0]  scsi_opcode;
        logic        force_unit_access;
        logic [31:0] command_block;
        logic [7:0]  command_blocks;
        logic [4:0]  allocation_length;
        logic [2:0]  completion_code;
    } t_out_item;

    typedef struct packed {
        logic        disk_ready;
        logic [16:0] bytes_per_block;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] last_tag;
    } t_step_status;

endpackage

/* hw/rtl/bot_in_if.sv */
// ----------------------------------------------------------------------------
// bot_in_if
// Input channel: requests, status wrappers and transport failures.
// ----------------------------------------------------------------------------
interface bot_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  request_op;
    logic [31:0] start_block;
    logic [31:0] block_total;
    logic [31:0] status_signature;
    logic [31:0] status_tag;
    logic [7:0]  status_code;

    modport source (
        output valid, kind, request_op, start_block, block_total,
               status_signature, status_tag, status_code,
        input  ready
    );
    modport sink (
        input  valid, kind, request_op, start_block, block_total,
               status_signature, status_tag, status_code,
        output ready
    );
endinterface

/* hw/rtl/bot_out_if.sv */
// ----------------------------------------------------------------------------
// bot_out_if
// Result channel: command wrappers to send and request completions.
// ----------------------------------------------------------------------------
interface bot_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] wrapper_tag;
    logic [23:0] transfer_bytes;
    logic        direction_in;
    logic [3:0]  command_length;
    logic [7:0]  scsi_opcode;
    logic        force_unit_access;
    logic [31:0] command_block;
    logic [7:0]  command_blocks;
    logic [4:0]  allocation_length;
    logic [2:0]  completion_code;

    modport source (
        output valid, result_kind, wrapper_tag, transfer_bytes, direction_in,
               command_length, scsi_opcode, force_unit_access, command_block,
               command_blocks, allocation_length, completion_code,
        input  ready
    );
    modport sink (
        input  valid, result_kind, wrapper_tag, transfer_bytes, direction_in,
               command_length, scsi_opcode, force_unit_access, command_block,
               command_blocks, allocation_length, completion_code,
        output ready
    );
endinterface

/* hw/rtl/bot_step.sv */
// ----------------------------------------------------------------------------
// bot_step
// Transport state, CBW/completion builder and result register.
// ----------------------------------------------------------------------------
module bot_step #(
    parameter int MAX_CHUNK = bot_pkg::MAX_CHUNK_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  bot_pkg::t_in_item    i_item,
    input  bot_pkg::t_cfg        i_cfg,
    output bot_pkg::t_out_item   o_res,
    output bot_pkg::t_step_status o_status
);
    import bot_pkg::*;

    // chunk size must fit the 8-bit block count
    localparam int CHUNK_LIM = (MAX_CHUNK < 1) ? 1 : ((MAX_CHUNK > 255) ? 255 : MAX_CHUNK);
    localparam logic [7:0]  LIM8  = 8'(CHUNK_LIM);
    localparam logic [31:0] LIM32 = 32'(CHUNK_LIM);

    t_phase      r_phase, n_phase;
    logic [31:0] r_last_tag, n_last_tag;
    logic [31:0] r_next_block, n_next_block;
    logic [31:0] r_blocks_left, n_blocks_left;
    logic [7:0]  r_chunk, n_chunk;
    logic [1:0]  r_op, n_op;
    t_out_item   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_last_tag    <= '0;
            r_next_block  <= '0;
            r_blocks_left <= '0;
            r_chunk       <= '0;
            r_op          <= OP_READ;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_last_tag    <= n_last_tag;
            r_next_block  <= n_next_block;
            r_blocks_left <= n_blocks_left;
            r_chunk       <= n_chunk;
            r_op          <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        logic        issue;
        logic        sense;
        logic        done;
        t_ccode      code;
        logic [31:0] iss_bl;
        logic [31:0] iss_nb;
        logic [7:0]  chunk;
        logic [24:0] bytes;

        n_phase       = r_phase;
        n_next_block  = r_next_block;
        n_blocks_left = r_blocks_left;
        n_chunk       = r_chunk;
        n_op          = r_op;
        issue         = 1'b0;
        sense         = 1'b0;
        done          = 1'b0;
        code          = CC_UNEXPECTED;
        iss_bl        = r_blocks_left;
        iss_nb        = r_next_block;

        case (i_item.kind)
            KIND_REQUEST: begin
                done = 1'b1;
                if (r_phase != PH_IDLE) begin
                    code = CC_BUSY;
                end else if (!i_cfg.disk_ready) begin
                    code = CC_NOT_READY;
                end else if (!(i_item.request_op inside {OP_READ, OP_WRITE, OP_FLUSH})) begin
                    code = CC_UNEXPECTED;
                end else begin
                    n_op          = i_item.request_op;
                    n_next_block  = i_item.start_block;
                    n_blocks_left = i_item.block_total;
                    if (i_item.request_op != OP_FLUSH && i_item.block_total == '0) begin
                        code = CC_OK;
                    end else begin
                        done    = 1'b0;
                        issue   = 1'b1;
                        n_phase = PH_CMD;
                        iss_bl  = i_item.block_total;
                        iss_nb  = i_item.start_block;
                    end
                end
            end
            KIND_STATUS: begin
                done = 1'b1;
                case (r_phase)
                    PH_SENSE: begin
                        n_phase = PH_IDLE;
                        code    = CC_FAILED;
                    end
                    PH_CMD: begin
                        n_phase = PH_IDLE;
                        if (i_item.status_signature != CSW_SIG
                            || i_item.status_tag != r_last_tag) begin
                            code = CC_BAD_CSW;
                        end else if (i_item.status_code == CSW_FAILED) begin
                            done    = 1'b0;
                            sense   = 1'b1;
                            n_phase = PH_SENSE;
                        end else if (i_item.status_code != CSW_PASSED) begin
                            code = CC_PHASE;
                        end else if (r_op == OP_FLUSH) begin
                            code = CC_OK;
                        end else begin
                            iss_nb        = r_next_block + 32'(r_chunk);
                            iss_bl        = r_blocks_left - 32'(r_chunk);
                            n_next_block  = iss_nb;
                            n_blocks_left = iss_bl;
                            if (iss_bl == '0) begin
                                code = CC_OK;
                            end else begin
                                done    = 1'b0;
                                issue   = 1'b1;
                                n_phase = PH_CMD;
                            end
                        end
                    end
                    default: code = CC_UNEXPECTED;
                endcase
            end
            KIND_XFAIL: begin
                done = 1'b1;
                case (r_phase)
                    PH_SENSE: begin
                        n_phase = PH_IDLE;
                        code    = CC_FAILED;
                    end
                    PH_CMD: begin
                        n_phase = PH_IDLE;
                        code    = CC_TRANSPORT;
                    end
                    default: code = CC_UNEXPECTED;
                endcase
            end
            default: begin
                done = 1'b1;
                code = CC_UNEXPECTED;
            end
        endcase

        // chunk and byte count for a READ(10)/WRITE(10)
        chunk = (iss_bl > LIM32) ? LIM8 : iss_bl[7:0];
        bytes = {17'd0, chunk} * {8'd0, i_cfg.bytes_per_block};

        n_last_tag = (issue || sense) ? r_last_tag + 32'd1 : r_last_tag;

        n_res = '0;
        if (done) begin
            n_res.result_kind     = RES_COMPLETION;
            n_res.completion_code = code;
        end else if (sense) begin
            n_res.result_kind       = RES_COMMAND;
            n_res.wrapper_tag       = n_last_tag;
            n_res.transfer_bytes    = 24'(SENSE_ALLOC_LEN);
            n_res.direction_in      = 1'b1;
            n_res.command_length    = CDB_LEN_6;
            n_res.scsi_opcode       = SCSI_REQ_SENSE;
            n_res.allocation_length = SENSE_ALLOC_LEN;
        end else begin
            n_res.result_kind    = RES_COMMAND;
            n_res.wrapper_tag    = n_last_tag;
            n_res.command_length = CDB_LEN_10;
            if (n_op == OP_FLUSH) begin
                n_chunk           = '0;
                n_res.scsi_opcode = SCSI_SYNC_CACHE10;
            end else begin
                n_chunk                 = chunk;
                n_res.transfer_bytes    = bytes[24] ? 24'hFF_FFFF : bytes[23:0];
                n_res.direction_in      = (n_op == OP_READ);
                n_res.scsi_opcode       = (n_op == OP_READ) ? SCSI_READ10 : SCSI_WRITE10;
                n_res.force_unit_access = (n_op == OP_WRITE);
                n_res.command_block     = iss_nb;
                n_res.command_blocks    = chunk;
            end
        end
    end

    assign o_res             = r_res;
    assign o_status.phase    = r_phase;
    assign o_status.last_tag = r_last_tag;

endmodule

/* hw/rtl/bulk_only_transport_host_engine_top.sv */
// ----------------------------------------------------------------------------
// bulk_only_transport_host_engine_top
// Host-side USB mass storage bulk-only transport command sequencer.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake        Transaction
//  ---------  ---  ---------------  ------------------------------------------
//  i_in       in   valid/ready      request, received CSW, or bulk failure
//  o_out      out  valid/ready      CBW fields to send, or request completion
//  i_cfg_*    in   write enable     disk_ready (index 0), bytes_per_block (1)
//
//  One result per input transaction. Input register, then one pass of step
//  logic into the result register; one transaction per cycle is sustained
//  while o_out.ready stays high. o_out.ready low holds the result register;
//  the input register then holds and i_in.ready drops. Synchronous active-low
//  reset empties both stages and sets idle, tag 0 and bytes_per_block 512.
//
`include "bulk_only_transport_host_engine_top_defines.svh"

module bulk_only_transport_host_engine_top #(
    parameter int MAX_CHUNK = bot_pkg::MAX_CHUNK_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bot_in_if.sink                          i_in,
    bot_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [bot_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bot_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bot_pkg::*;

    // configuration registers
    t_cfg         r_cfg;

    // input stage
    logic         r_s1_valid;
    t_in_item     r_s1_item;
    t_in_item     in_item;

    // result stage
    logic         r_out_valid;
    t_out_item    res;
    t_step_status status;

    logic         advance;   // result slot free or being drained this cycle
    logic         fire;      // input stage moves through the step logic
    logic         in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disk_ready      <= 1'b0;
            r_cfg.bytes_per_block <= BPB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISK_READY:      r_cfg.disk_ready      <= i_cfg_data[0];
                CFG_BYTES_PER_BLOCK: r_cfg.bytes_per_block <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance   = !r_out_valid || o_out.ready;
    assign fire      = r_s1_valid && advance;
    assign i_in.ready = !r_s1_valid || advance;
    assign in_accept = i_in.valid && i_in.ready;

    assign in_item.kind             = i_in.kind;
    assign in_item.request_op       = i_in.request_op;
    assign in_item.start_block      = i_in.start_block;
    assign in_item.block_total      = i_in.block_total;
    assign in_item.status_signature = i_in.status_signature;
    assign in_item.status_tag       = i_in.status_tag;
    assign in_item.status_code      = i_in.status_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // transport state and result register
    bot_step #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .o_res    (res),
        .o_status (status)
    );

    assign o_out.valid             = r_out_valid;
    assign o_out.result_kind       = res.result_kind;
    assign o_out.wrapper_tag       = res.wrapper_tag;
    assign o_out.transfer_bytes    = res.transfer_bytes;
    assign o_out.direction_in      = res.direction_in;
    assign o_out.command_length    = res.command_length;
    assign o_out.scsi_opcode       = res.scsi_opcode;
    assign o_out.force_unit_access = res.force_unit_access;
    assign o_out.command_block     = res.command_block;
    assign o_out.command_blocks    = res.command_blocks;
    assign o_out.allocation_length = res.allocation_length;
    assign o_out.completion_code   = res.completion_code;

    // A completion carries nothing but its code
    `BOT_ASSERT_IMP(a_completion_clean, i_clk, i_rst_n,
        o_out.valid && o_out.result_kind == RES_COMPLETION,
        o_out.wrapper_tag == '0 && o_out.transfer_bytes == '0 && o_out.command_blocks == '0)

    // A pending CBW always carries the most recently issued tag
    `BOT_ASSERT_IMP(a_cbw_tag_current, i_clk, i_rst_n,
        o_out.valid && o_out.result_kind == RES_COMMAND,
        o_out.wrapper_tag == status.last_tag && status.phase != PH_IDLE)

    // Status or failure while idle is reported as unexpected
    `BOT_ASSERT_NXT(a_idle_unexpected, i_clk, i_rst_n,
        fire && status.phase == PH_IDLE && r_s1_item.kind != KIND_REQUEST,
        o_out.valid && o_out.result_kind == RES_COMPLETION
            && o_out.completion_code == CC_UNEXPECTED)

endmodule
